[sv/lpl_pkg.sv]
// Shared types, constants and a helper function of the lookahead peak limiter.
`default_nettype none
package lpl_pkg;

  localparam int GAIN_W = 24;
  localparam int LEN_W = 10;
  localparam int STAMP_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DIV_STEPS = 23;

  localparam logic [GAIN_W-1:0] UNITY = 24'd8388608;

  // Register reset values.
  localparam logic [GAIN_W-1:0] RST_CEILING = 24'd8103858;
  localparam logic [LEN_W-1:0] RST_LOOKAHEAD = 10'd288;
  localparam logic [GAIN_W-1:0] RST_ATTACK = 24'd115700;
  localparam logic [GAIN_W-1:0] RST_ATTACK2 = 24'd172955;
  localparam logic [GAIN_W-1:0] RST_RELEASE = 24'd874;
  localparam logic RST_STEREO = 1'b1;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CEILING   = 3'd0,
    CFG_LOOKAHEAD = 3'd1,
    CFG_ATTACK    = 3'd2,
    CFG_ATTACK2   = 3'd3,
    CFG_RELEASE   = 3'd4,
    CFG_STEREO    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] ceiling_gain;
    logic [LEN_W-1:0]  lookahead_length;
    logic [GAIN_W-1:0] attack_coeff;
    logic [GAIN_W-1:0] attack_coeff_second;
    logic [GAIN_W-1:0] release_coeff;
    logic              stereo_mode;
  } cfg_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CHECK,
    FE_DIV,
    FE_PUSH
  } fe_state_t;

  typedef enum logic [3:0] {
    BE_CLEAR,
    BE_IDLE,
    BE_TAIL_RD,
    BE_TAIL_CMP,
    BE_WRITE,
    BE_HEAD_RD,
    BE_HEAD_CMP,
    BE_SM1_MUL,
    BE_SM1_ADD,
    BE_SM2_MUL,
    BE_SM2_ADD,
    BE_OUTL_MUL,
    BE_OUTL_FIN,
    BE_OUTR_MUL,
    BE_OUTR_FIN,
    BE_DONE
  } be_state_t;

  // Gains and coefficients above 1.0 act as 1.0.
  function automatic logic [GAIN_W-1:0] sat_unity(input logic [GAIN_W-1:0] v);
    return (v > UNITY) ? UNITY : v;
  endfunction

endpackage
`default_nettype wire

[sv/lpl_if.sv]
// Channel interfaces: input frames, limited results and configuration writes.
`default_nettype none
interface lpl_in_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_left;
  logic signed [SAMPLE_BITS-1:0] sample_right;
  modport source (output valid, sample_left, sample_right, input ready);
  modport sink (input valid, sample_left, sample_right, output ready);
endinterface

interface lpl_out_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  logic [23:0]                   applied_gain;
  modport source (output valid, out_left, out_right, applied_gain, input ready);
  modport sink (input valid, out_left, out_right, applied_gain, output ready);
endinterface

interface lpl_cfg_if ();
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/lpl_ram.sv]
// Generic single-port RAM with registered read data.
`default_nettype none
module lpl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic                     we,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read share one address; read data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

[sv/lpl_fifo.sv]
// Short register queue between the front and back parts.
`default_nettype none
module lpl_fifo #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data = slot_r[rd_ptr_r];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  // Payload slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[sv/lpl_front.sv]
// Front part: accepts a frame, finds its peak and divides out the required gain.
`default_nettype none
module lpl_front #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire lpl_pkg::cfg_t                   cfg,
  input  wire logic                            enable,
  lpl_in_if.sink                               in_chan,
  output logic                                 push_valid,
  input  wire logic                            push_ready,
  output logic [lpl_pkg::GAIN_W+2*SAMPLE_BITS-1:0] push_data
);

  import lpl_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int FRAC = SB - 5;
  localparam int CW = GAIN_W + FRAC;
  localparam int STEP_W = $clog2(DIV_STEPS);

  fe_state_t state_r, state_nxt;

  logic signed [SB-1:0] xl_r, xr_r;
  logic [SB-1:0]        pk_r;
  logic [SB:0]          rem_r;
  logic [22:0]          lo_r;
  logic [GAIN_W-1:0]    q_r;
  logic [STEP_W-1:0]    step_r;

  logic [SB-1:0]        abs_l, abs_r, pk_in;
  logic [CW-1:0]        cscaled;
  logic                 need_div, accept, div_last;
  logic [SB:0]          trial;
  logic                 q_bit;

  // Peak magnitude of the incoming word; mono ignores the right channel.
  always_comb begin
    abs_l = in_chan.sample_left[SB-1] ? (~in_chan.sample_left + 1'b1) : in_chan.sample_left;
    abs_r = in_chan.sample_right[SB-1] ? (~in_chan.sample_right + 1'b1)
                                       : in_chan.sample_right;
    if (!cfg.stereo_mode) begin
      abs_r = '0;
    end
    pk_in = (abs_r > abs_l) ? abs_r : abs_l;
  end

  // Ceiling in sample scale and the test for a gain below unity.
  assign cscaled = {sat_unity(cfg.ceiling_gain), {FRAC{1'b0}}};
  assign need_div = ({pk_r, 23'd0} > (SB + 23)'(cscaled));

  // One restoring division step per cycle.
  assign trial = {rem_r[SB-1:0], lo_r[22]};
  assign q_bit = (trial >= {1'b0, pk_r});
  assign div_last = (step_r == STEP_W'(DIV_STEPS - 1));
  assign accept = in_chan.valid && in_chan.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FE_IDLE:  if (accept) state_nxt = FE_CHECK;
      FE_CHECK: state_nxt = need_div ? FE_DIV : FE_PUSH;
      FE_DIV:   if (div_last) state_nxt = FE_PUSH;
      FE_PUSH:  if (push_ready) state_nxt = FE_IDLE;
      default:  state_nxt = FE_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_chan.ready = (state_r == FE_IDLE) && enable;
    push_valid = (state_r == FE_PUSH);
    push_data = {q_r, xl_r, xr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      FE_IDLE: begin
        if (accept) begin
          xl_r <= in_chan.sample_left;
          xr_r <= cfg.stereo_mode ? in_chan.sample_right : '0;
          pk_r <= pk_in;
        end
      end
      FE_CHECK: begin
        rem_r <= (SB + 1)'(cscaled[CW-1:23]);
        lo_r <= cscaled[22:0];
        q_r <= need_div ? '0 : UNITY;
        step_r <= '0;
      end
      FE_DIV: begin
        rem_r <= q_bit ? (trial - {1'b0, pk_r}) : trial;
        lo_r <= {lo_r[21:0], 1'b0};
        q_r <= {q_r[GAIN_W-2:0], q_bit};
        step_r <= step_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[sv/lpl_back.sv]
// Back part: window minimum deque, two gain smoothers, delay lines and output.
`default_nettype none
module lpl_back #(
  parameter int LOOKAHEAD_MAX = 512,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire lpl_pkg::cfg_t                       cfg,
  input  wire logic                                pop_valid,
  output logic                                     pop_ready,
  input  wire logic [lpl_pkg::GAIN_W+2*SAMPLE_BITS-1:0] pop_data,
  output logic                                     clearing,
  lpl_out_if.source                                out_chan
);

  import lpl_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int FRAC = SB - 5;
  localparam int CW = GAIN_W + FRAC;
  localparam int RING = LOOKAHEAD_MAX + 2;
  localparam int RW = $clog2(RING);
  localparam int CNT_W = $clog2(RING + 1);
  localparam int PW = $clog2(LOOKAHEAD_MAX);
  localparam int LW = $clog2(LOOKAHEAD_MAX + 1);
  localparam int AW = (SB > GAIN_W) ? SB : GAIN_W;
  localparam int PRW = AW + GAIN_W;
  localparam int PMW = PRW - 23;
  localparam int DQW = GAIN_W + STAMP_W;
  localparam logic [PRW-1:0] RND_HALF = PRW'(1) << 22;

  be_state_t state_r, state_nxt;

  logic [GAIN_W-1:0]    req_r, gmin_r, g1_r, g2_r;
  logic signed [SB-1:0] xl_r, xr_r, yl_r, yr_r;
  logic [RW-1:0]        head_r;
  logic [CNT_W-1:0]     count_r;
  logic [STAMP_W-1:0]   counter_r;
  logic [PW-1:0]        pos_r;
  logic [PRW-1:0]       prod_r;
  logic                 neg_r;
  logic                 out_valid_r;
  logic signed [SB-1:0] out_left_r, out_right_r;
  logic [GAIN_W-1:0]    out_gain_r;

  logic [LW-1:0]        len;
  logic [CW-1:0]        cscaled;
  logic [PMW-1:0]       ceil_m;
  logic [RW:0]          tail_sum, tail_m1_sum;
  logic [RW-1:0]        tail, tail_m1;
  logic [STAMP_W-1:0]   age;
  logic                 aged, out_free;

  logic [RW-1:0]        dq_addr;
  logic                 dq_we, dq_re;
  logic [DQW-1:0]       dq_rdata;
  logic [GAIN_W-1:0]    dq_gain;
  logic [STAMP_W-1:0]   dq_stamp;
  logic                 dl_we, dr_we, dly_re, dr_re;
  logic signed [SB-1:0] dl_wdata, dr_wdata, dl_rdata, dr_rdata;

  logic [GAIN_W-1:0]    sm_target, sm_g, sm_coeff, sm_mag, sm_res;
  logic                 sm_neg;
  logic [AW-1:0]        mul_a;
  logic [GAIN_W-1:0]    mul_b;
  logic                 mul_neg;
  logic [PRW-1:0]       rnd;
  logic [PMW-1:0]       p_mag, p_clamp;
  logic [PMW+1:0]       sm_sum;
  logic signed [SB-1:0] y_fin;
  logic [SB-1:0]        abs_dl, abs_dr;
  logic [PW:0]          pos_p1;

  // Effective window length: zero acts as one, large values as the maximum.
  always_comb begin
    if (cfg.lookahead_length == '0) begin
      len = LW'(1);
    end else if (32'(cfg.lookahead_length) > 32'(LOOKAHEAD_MAX)) begin
      len = LW'(LOOKAHEAD_MAX);
    end else begin
      len = LW'(cfg.lookahead_length);
    end
  end

  // Output clamp level in sample scale.
  assign cscaled = {sat_unity(cfg.ceiling_gain), {FRAC{1'b0}}};
  assign ceil_m = PMW'(cscaled[CW-1:23]);

  // Ring addresses of the deque tail.
  always_comb begin
    tail_sum = (RW + 1)'(head_r) + (RW + 1)'(count_r);
    tail_m1_sum = tail_sum - 1'b1;
    tail = (tail_sum >= (RW + 1)'(RING)) ? RW'(tail_sum - (RW + 1)'(RING)) : RW'(tail_sum);
    tail_m1 = (tail_m1_sum >= (RW + 1)'(RING)) ? RW'(tail_m1_sum - (RW + 1)'(RING))
                                               : RW'(tail_m1_sum);
  end

  assign dq_gain = dq_rdata[DQW-1:STAMP_W];
  assign dq_stamp = dq_rdata[STAMP_W-1:0];
  assign age = counter_r - dq_stamp;
  assign aged = (count_r != '0) && (32'(age) >= 32'(len));
  assign out_free = !out_valid_r || out_chan.ready;

  // Smoother operands: stage one follows the window minimum, stage two stage one.
  always_comb begin
    if (state_r == BE_SM1_MUL || state_r == BE_SM1_ADD) begin
      sm_target = gmin_r;
      sm_g = g1_r;
    end else begin
      sm_target = g1_r;
      sm_g = g2_r;
    end
    sm_neg = (sm_target < sm_g);
    sm_mag = sm_neg ? (sm_g - sm_target) : (sm_target - sm_g);
    if (state_r == BE_SM1_MUL) begin
      sm_coeff = sm_neg ? sat_unity(cfg.attack_coeff) : sat_unity(cfg.release_coeff);
    end else begin
      sm_coeff = sm_neg ? sat_unity(cfg.attack_coeff_second) : sat_unity(cfg.release_coeff);
    end
  end

  // Shared multiplier operands.
  always_comb begin
    abs_dl = dl_rdata[SB-1] ? (~dl_rdata + 1'b1) : dl_rdata;
    abs_dr = dr_rdata[SB-1] ? (~dr_rdata + 1'b1) : dr_rdata;
    case (state_r)
      BE_OUTL_MUL: begin
        mul_a = AW'(abs_dl);
        mul_b = g2_r;
        mul_neg = dl_rdata[SB-1];
      end
      BE_OUTR_MUL: begin
        mul_a = AW'(abs_dr);
        mul_b = g2_r;
        mul_neg = dr_rdata[SB-1];
      end
      default: begin
        mul_a = AW'(sm_mag);
        mul_b = sm_coeff;
        mul_neg = sm_neg;
      end
    endcase
  end

  // Rounding, smoother update with clamping, and output clamp.
  always_comb begin
    rnd = prod_r + RND_HALF;
    p_mag = rnd[PRW-1:23];
    sm_sum = (PMW + 2)'(sm_g) + (PMW + 2)'(p_mag);
    if (neg_r) begin
      sm_res = ((PMW + 2)'(p_mag) > (PMW + 2)'(sm_g)) ? '0 : GAIN_W'(sm_g - GAIN_W'(p_mag));
    end else begin
      sm_res = (sm_sum > (PMW + 2)'(UNITY)) ? UNITY : GAIN_W'(sm_sum);
    end
    p_clamp = (p_mag > ceil_m) ? ceil_m : p_mag;
    y_fin = neg_r ? -SB'(p_clamp) : SB'(p_clamp);
  end

  assign pos_p1 = (PW + 1)'(pos_r) + 1'b1;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BE_CLEAR:    if (pos_r == PW'(LOOKAHEAD_MAX - 1)) state_nxt = BE_IDLE;
      BE_IDLE:     if (pop_valid) state_nxt = BE_TAIL_RD;
      BE_TAIL_RD:  state_nxt = (count_r == '0) ? BE_WRITE : BE_TAIL_CMP;
      BE_TAIL_CMP: state_nxt = (dq_gain >= req_r) ? BE_TAIL_RD : BE_WRITE;
      BE_WRITE:    state_nxt = BE_HEAD_RD;
      BE_HEAD_RD:  state_nxt = BE_HEAD_CMP;
      BE_HEAD_CMP: state_nxt = aged ? BE_HEAD_RD : BE_SM1_MUL;
      BE_SM1_MUL:  state_nxt = BE_SM1_ADD;
      BE_SM1_ADD:  state_nxt = BE_SM2_MUL;
      BE_SM2_MUL:  state_nxt = BE_SM2_ADD;
      BE_SM2_ADD:  state_nxt = BE_OUTL_MUL;
      BE_OUTL_MUL: state_nxt = BE_OUTL_FIN;
      BE_OUTL_FIN: state_nxt = cfg.stereo_mode ? BE_OUTR_MUL : BE_DONE;
      BE_OUTR_MUL: state_nxt = BE_OUTR_FIN;
      BE_OUTR_FIN: state_nxt = BE_DONE;
      BE_DONE:     if (out_free) state_nxt = BE_IDLE;
      default:     state_nxt = BE_IDLE;
    endcase
  end

  // Memory controls and handshake outputs.
  always_comb begin
    pop_ready = (state_r == BE_IDLE);
    clearing = (state_r == BE_CLEAR);
    dq_re = (state_r == BE_TAIL_RD && count_r != '0) || (state_r == BE_HEAD_RD);
    dq_we = (state_r == BE_WRITE);
    case (state_r)
      BE_TAIL_RD: dq_addr = tail_m1;
      BE_WRITE:   dq_addr = tail;
      default:    dq_addr = head_r;
    endcase
    dly_re = (state_r == BE_WRITE);
    dr_re = dly_re && cfg.stereo_mode;
    dl_we = clearing || (state_r == BE_HEAD_RD);
    dr_we = clearing || (state_r == BE_HEAD_RD && cfg.stereo_mode);
    dl_wdata = clearing ? '0 : xl_r;
    dr_wdata = clearing ? '0 : xr_r;
    out_chan.valid = out_valid_r;
    out_chan.out_left = out_left_r;
    out_chan.out_right = out_right_r;
    out_chan.applied_gain = out_gain_r;
  end

  // Deque of gain and stamp, and the two delay lines.
  lpl_ram #(.WIDTH(DQW), .DEPTH(RING)) u_dq_ram (
    .clk   (clk),
    .addr  (dq_addr),
    .we    (dq_we),
    .wdata ({req_r, counter_r}),
    .re    (dq_re),
    .rdata (dq_rdata)
  );

  lpl_ram #(.WIDTH(SB), .DEPTH(LOOKAHEAD_MAX)) u_dl_ram (
    .clk   (clk),
    .addr  (pos_r),
    .we    (dl_we),
    .wdata (dl_wdata),
    .re    (dly_re),
    .rdata (dl_rdata)
  );

  lpl_ram #(.WIDTH(SB), .DEPTH(LOOKAHEAD_MAX)) u_dr_ram (
    .clk   (clk),
    .addr  (pos_r),
    .we    (dr_we),
    .wdata (dr_wdata),
    .re    (dr_re),
    .rdata (dr_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BE_CLEAR;
      head_r <= '0;
      count_r <= '0;
      counter_r <= '0;
      pos_r <= '0;
      g1_r <= UNITY;
      g2_r <= UNITY;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // The output word is loaded when the back finishes and cleared once taken.
      if (state_r == BE_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        BE_CLEAR: begin
          pos_r <= (pos_r == PW'(LOOKAHEAD_MAX - 1)) ? '0 : pos_r + 1'b1;
        end
        BE_IDLE: begin
          if (pop_valid && 32'(pos_r) >= 32'(len)) begin
            pos_r <= '0;
          end
        end
        BE_TAIL_CMP: begin
          if (dq_gain >= req_r) begin
            count_r <= count_r - 1'b1;
          end
        end
        BE_WRITE: begin
          count_r <= count_r + 1'b1;
        end
        BE_HEAD_CMP: begin
          if (aged) begin
            head_r <= (head_r == RW'(RING - 1)) ? '0 : head_r + 1'b1;
            count_r <= count_r - 1'b1;
          end
        end
        BE_SM1_ADD: g1_r <= sm_res;
        BE_SM2_ADD: g2_r <= sm_res;
        BE_DONE: begin
          if (out_free) begin
            counter_r <= counter_r + 1'b1;
            pos_r <= (32'(pos_p1) >= 32'(len)) ? '0 : PW'(pos_p1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state_r)
      BE_IDLE: begin
        if (pop_valid) begin
          req_r <= pop_data[GAIN_W+2*SB-1:2*SB];
          xl_r <= pop_data[2*SB-1:SB];
          xr_r <= pop_data[SB-1:0];
        end
      end
      BE_HEAD_CMP: begin
        if (!aged) begin
          gmin_r <= dq_gain;
        end
      end
      BE_SM1_MUL, BE_SM2_MUL, BE_OUTL_MUL, BE_OUTR_MUL: begin
        prod_r <= PRW'(mul_a) * PRW'(mul_b);
        neg_r <= mul_neg;
      end
      BE_SM2_ADD: yr_r <= '0;
      BE_OUTL_FIN: yl_r <= y_fin;
      BE_OUTR_FIN: yr_r <= y_fin;
      BE_DONE: begin
        if (out_free) begin
          out_left_r <= yl_r;
          out_right_r <= yr_r;
          out_gain_r <= g2_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[sv/lookahead_peak_limiter_core.sv]
// Top level of the lookahead peak limiter: register file, front, queue and back.
//
//   Channel   Direction  Handshake     Word
//   in_chan   in         valid/ready   sample_left, sample_right
//   out_chan  out        valid/ready   out_left, out_right, applied_gain
//   cfg_chan  in         valid/ready   index, data (register write)
//
// The front checks and pushes a word below the ceiling, or first runs the division
// when the gain must be divided out (one quotient bit per cycle). The back walks the
// deque tail and head, then the smoothers and output; pops are amortized to one per
// word. After reset every LOOKAHEAD_MAX entry of the delay lines is zeroed before the
// first word. A two-entry queue and the output register let each side stall on its own.
`default_nettype none
module lookahead_peak_limiter_core #(
  parameter int LOOKAHEAD_MAX = 512,
  parameter int SAMPLE_BITS = 24
) (
  input wire logic   clk,
  input wire logic   rst_n,
  lpl_in_if.sink     in_chan,
  lpl_out_if.source  out_chan,
  lpl_cfg_if.sink    cfg_chan
);

  import lpl_pkg::*;

  localparam int QW = GAIN_W + 2 * SAMPLE_BITS;

  cfg_t             cfg_r;
  logic             clearing;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  logic [QW-1:0]    push_data, pop_data;

  assign cfg_chan.ready = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ceiling_gain <= RST_CEILING;
      cfg_r.lookahead_length <= RST_LOOKAHEAD;
      cfg_r.attack_coeff <= RST_ATTACK;
      cfg_r.attack_coeff_second <= RST_ATTACK2;
      cfg_r.release_coeff <= RST_RELEASE;
      cfg_r.stereo_mode <= RST_STEREO;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_CEILING:   cfg_r.ceiling_gain <= cfg_chan.data;
        CFG_LOOKAHEAD: cfg_r.lookahead_length <= cfg_chan.data[LEN_W-1:0];
        CFG_ATTACK:    cfg_r.attack_coeff <= cfg_chan.data;
        CFG_ATTACK2:   cfg_r.attack_coeff_second <= cfg_chan.data;
        CFG_RELEASE:   cfg_r.release_coeff <= cfg_chan.data;
        CFG_STEREO:    cfg_r.stereo_mode <= cfg_chan.data[0];
        default: begin
        end
      endcase
    end
  end

  lpl_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .enable     (!clearing),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  lpl_fifo #(.WIDTH(QW), .DEPTH(2)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lpl_back #(.LOOKAHEAD_MAX(LOOKAHEAD_MAX), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .clearing  (clearing),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire

[tb/sv/tb_lookahead_peak_limiter_core.sv]
// Testbench for the lookahead peak limiter core: random and directed frames checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_lookahead_peak_limiter_core;
  import lpl_pkg::*;

  localparam int LA_MAX = 512;
  localparam int SBITS = 24;
  localparam int FRAC = SBITS - 5;
  localparam int RING = LA_MAX + 2;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [SBITS-1:0] left;
    logic signed [SBITS-1:0] right;
  } frame_t;

  typedef struct packed {
    logic signed [SBITS-1:0] left;
    logic signed [SBITS-1:0] right;
    logic [23:0]             gain;
  } limited_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lpl_in_if #(.SAMPLE_BITS(SBITS)) in_chan ();
  lpl_out_if #(.SAMPLE_BITS(SBITS)) out_chan ();
  lpl_cfg_if cfg_chan ();

  lookahead_peak_limiter_core #(.LOOKAHEAD_MAX(LA_MAX), .SAMPLE_BITS(SBITS)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  // Clock generation.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state and its copy of the registers.
  logic [23:0] p_ceiling, p_attack, p_attack2, p_release;
  logic [9:0]  p_length;
  logic        p_stereo;
  logic signed [SBITS-1:0] p_delay_l [LA_MAX];
  logic signed [SBITS-1:0] p_delay_r [LA_MAX];
  logic [23:0] p_dq_gain [RING];
  logic [15:0] p_dq_stamp [RING];
  int          p_dq_head, p_dq_count, p_delay_pos;
  logic [15:0] p_counter;
  logic [23:0] p_gain1, p_gain2;

  frame_t   frame_queue[$];
  limited_t expected_queue[$];
  int       fail_count = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  int       quiet_cycles = 0;

  // Pending register write, taken by the driver between bursts.
  bit          cfg_pending = 1'b0;
  cfg_idx_t    cfg_pend_idx;
  logic [23:0] cfg_pend_data;

  function automatic logic [23:0] clip_unity(logic [23:0] v);
    return (v > UNITY) ? UNITY : v;
  endfunction

  // round(a * coeff / 2^23), half away from zero.
  function automatic longint scale_q23(longint a, longint coeff);
    longint mag, p;
    mag = (a < 0) ? -a : a;
    p = (mag * coeff + (64'sd1 <<< 22)) >>> 23;
    return (a < 0) ? -p : p;
  endfunction

  function automatic logic [23:0] follow(logic [23:0] g, logic [23:0] target, logic [23:0] c);
    longint r;
    r = longint'(g) + scale_q23(longint'(target) - longint'(g), longint'(c));
    if (r < 0) r = 0;
    if (r > longint'(UNITY)) r = longint'(UNITY);
    return r[23:0];
  endfunction

  function automatic longint clamp_ceiling(longint d, logic [23:0] g, longint cs);
    longint y;
    y = scale_q23(d, longint'(g));
    if (y > cs) y = cs;
    if (y < -cs) y = -cs;
    return y;
  endfunction

  task automatic predictor_reset();
    p_ceiling = RST_CEILING;
    p_length = RST_LOOKAHEAD;
    p_attack = RST_ATTACK;
    p_attack2 = RST_ATTACK2;
    p_release = RST_RELEASE;
    p_stereo = RST_STEREO;
    for (int i = 0; i < LA_MAX; i++) begin
      p_delay_l[i] = '0;
      p_delay_r[i] = '0;
    end
    for (int i = 0; i < RING; i++) begin
      p_dq_gain[i] = UNITY;
      p_dq_stamp[i] = '0;
    end
    p_dq_head = 0;
    p_dq_count = 0;
    p_delay_pos = 0;
    p_counter = '0;
    p_gain1 = UNITY;
    p_gain2 = UNITY;
  endtask

  task automatic predictor_write(cfg_idx_t idx, logic [23:0] data);
    case (idx)
      CFG_CEILING: p_ceiling = data;
      CFG_LOOKAHEAD: p_length = data[9:0];
      CFG_ATTACK: p_attack = data;
      CFG_ATTACK2: p_attack2 = data;
      CFG_RELEASE: p_release = data;
      CFG_STEREO: p_stereo = data[0];
      default: ;
    endcase
  endtask

  // Work out the limited word for one accepted frame.
  task automatic limit_frame(frame_t f);
    int len, tail;
    longint cg, xl, xr, pk, ar, cscaled, req, ceil_s, dl, dr, yl, yr;
    logic [23:0] gmin, atk, atk2, rel;
    limited_t res;
    len = p_length;
    if (len < 1) len = 1;
    if (len > LA_MAX) len = LA_MAX;
    cg = clip_unity(p_ceiling);
    atk = clip_unity(p_attack);
    atk2 = clip_unity(p_attack2);
    rel = clip_unity(p_release);
    xl = longint'(f.left);
    xr = p_stereo ? longint'(f.right) : 0;
    pk = (xl < 0) ? -xl : xl;
    ar = (xr < 0) ? -xr : xr;
    if (ar > pk) pk = ar;
    cscaled = cg <<< FRAC;
    req = UNITY;
    if ((pk <<< 23) > cscaled) req = cscaled / pk;
    ceil_s = cscaled >>> 23;
    // Monotonic deque: drop tail entries no smaller than the new gain.
    while (p_dq_count > 0 &&
           p_dq_gain[(p_dq_head + p_dq_count - 1) % RING] >= req[23:0])
      p_dq_count--;
    tail = (p_dq_head + p_dq_count) % RING;
    p_dq_gain[tail] = req[23:0];
    p_dq_stamp[tail] = p_counter;
    p_dq_count++;
    while (p_dq_count > 0 && int'(16'(p_counter - p_dq_stamp[p_dq_head])) >= len) begin
      p_dq_head = (p_dq_head + 1) % RING;
      p_dq_count--;
    end
    gmin = p_dq_gain[p_dq_head];
    p_gain1 = follow(p_gain1, gmin, (gmin < p_gain1) ? atk : rel);
    p_gain2 = follow(p_gain2, p_gain1, (p_gain1 < p_gain2) ? atk2 : rel);
    if (p_delay_pos >= len) p_delay_pos = 0;
    dl = longint'(p_delay_l[p_delay_pos]);
    p_delay_l[p_delay_pos] = f.left;
    yl = clamp_ceiling(dl, p_gain2, ceil_s);
    yr = 0;
    if (p_stereo) begin
      dr = longint'(p_delay_r[p_delay_pos]);
      p_delay_r[p_delay_pos] = f.right;
      yr = clamp_ceiling(dr, p_gain2, ceil_s);
    end
    p_delay_pos++;
    if (p_delay_pos >= len) p_delay_pos = 0;
    p_counter = p_counter + 16'd1;
    res.left = yl[SBITS-1:0];
    res.right = yr[SBITS-1:0];
    res.gain = p_gain2;
    expected_queue.push_back(res);
  endtask

  // Driver: frames from the queue, register writes when flagged.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.sample_left <= '0;
      in_chan.sample_right <= '0;
      cfg_chan.valid <= 1'b0;
      cfg_chan.index <= CFG_CEILING;
      cfg_chan.data <= '0;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        predictor_write(cfg_idx_t'(cfg_chan.index), cfg_chan.data);
        cfg_pending = 1'b0;
      end
      if (in_chan.valid && in_chan.ready) begin
        limit_frame(frame_t'({in_chan.sample_left, in_chan.sample_right}));
        void'(frame_queue.pop_front());
      end
      cfg_chan.valid <= cfg_pending;
      cfg_chan.index <= cfg_pend_idx;
      cfg_chan.data <= cfg_pend_data;
      if (frame_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_chan.valid <= 1'b1;
        in_chan.sample_left <= frame_queue[0].left;
        in_chan.sample_right <= frame_queue[0].right;
      end else if (!(in_chan.valid && !in_chan.ready)) begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each limited word with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_queue.size() == 0) begin
          $error("unexpected word: left %0d right %0d gain %0d",
                 out_chan.out_left, out_chan.out_right, out_chan.applied_gain);
          fail_count++;
        end else begin
          limited_t e;
          e = expected_queue.pop_front();
          if (out_chan.out_left !== e.left) begin
            $error("out_left expected %0d actual %0d", e.left, out_chan.out_left);
            fail_count++;
          end
          if (out_chan.out_right !== e.right) begin
            $error("out_right expected %0d actual %0d", e.right, out_chan.out_right);
            fail_count++;
          end
          if (out_chan.applied_gain !== e.gain) begin
            $error("applied_gain expected %0d actual %0d", e.gain, out_chan.applied_gain);
            fail_count++;
          end
        end
      end
      out_chan.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles with no handshake; the reset clearing pass fits well inside.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (frame_queue.size() > 0 || expected_queue.size() > 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [23:0] data);
    cfg_pend_idx = idx;
    cfg_pend_data = data;
    cfg_pending = 1'b1;
    while (cfg_pending) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'(int'($urandom_range(4000)) - 2000);
      default: return 24'($urandom);
    endcase
  endfunction

  // Mostly quiet content with bursts of loud peaks, so the limiter engages and releases.
  task automatic push_random(int n);
    int loud;
    loud = 0;
    for (int i = 0; i < n; i++) begin
      frame_t f;
      if ($urandom_range(99) < 4) loud = $urandom_range(40, 1);
      if (loud > 0) begin
        f.left = rand_sample();
        f.right = rand_sample();
        loud--;
      end else begin
        f.left = 24'(int'($urandom_range(1 << 19)) - (1 << 18));
        f.right = 24'(int'($urandom_range(1 << 19)) - (1 << 18));
      end
      frame_queue.push_back(f);
    end
  endtask

  task automatic random_setting(bit extreme);
    write_reg(CFG_CEILING, extreme ? (($urandom_range(1)) ? 24'd4194304 : 24'hFFFFFF)
                                   : 24'($urandom_range(8388608, 4194304)));
    write_reg(CFG_LOOKAHEAD, extreme ? (($urandom_range(1)) ? 24'd0 : 24'h3FF)
                                     : 24'($urandom_range(40, 1)));
    write_reg(CFG_ATTACK, extreme ? 24'hFFFFFF : 24'($urandom_range(8388608)));
    write_reg(CFG_ATTACK2, extreme ? 24'd0 : 24'($urandom_range(8388608)));
    write_reg(CFG_RELEASE, extreme ? 24'd8388608 : 24'($urandom_range(200000)));
    write_reg(CFG_STEREO, 24'($urandom_range(1)));
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.sample_left = '0;
    in_chan.sample_right = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = CFG_CEILING;
    cfg_chan.data = '0;
    predictor_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes at reset settings, mono, window shrink, unknown register.
    frame_queue.push_back('{24'h7FFFFF, 24'h800000});
    frame_queue.push_back('{24'h800000, 24'h7FFFFF});
    frame_queue.push_back('{24'h000000, 24'h000000});
    frame_queue.push_back('{24'h000001, 24'hFFFFFF});
    frame_queue.push_back('{24'h3DD3C0, 24'hC22C40});
    frame_queue.push_back('{24'h555555, 24'hAAAAAA});
    wait_drained();
    write_reg(CFG_STEREO, 24'd0);
    write_reg(CFG_LOOKAHEAD, 24'd3);
    write_reg(cfg_idx_t'(3'd7), 24'hFFFFFF);
    write_reg(cfg_idx_t'(3'd6), 24'h123456);
    frame_queue.push_back('{24'h7FFFFF, 24'h7FFFFF});
    frame_queue.push_back('{24'h100000, 24'h800000});
    frame_queue.push_back('{24'h800000, 24'h000000});
    frame_queue.push_back('{24'h000010, 24'h7FFFFF});
    wait_drained();
    write_reg(CFG_LOOKAHEAD, 24'd1);
    write_reg(CFG_STEREO, 24'd1);
    write_reg(CFG_CEILING, 24'hFFFFFF);
    frame_queue.push_back('{24'h7FFFFF, 24'h800000});
    frame_queue.push_back('{24'h800000, 24'h7FFFFF});
    frame_queue.push_back('{24'h400000, 24'h000000});
    wait_drained();

    // Random phases across idling patterns and settings.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      random_setting(ph % 3 == 0);
      push_random(75);
      // Hold the sender until every expected word is back, then continue.
      while (frame_queue.size() > 0 || expected_queue.size() > 0) @(posedge clk);
      push_random(75);
      wait_drained();
    end
    idle_pct = 0;
    stall_pct = 0;
    write_reg(CFG_LOOKAHEAD, 24'd512);
    push_random(20);
    wait_drained();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
sv/lpl_pkg.sv
sv/lpl_if.sv
sv/lpl_ram.sv
sv/lpl_fifo.sv
sv/lpl_front.sv
sv/lpl_back.sv
sv/lookahead_peak_limiter_core.sv
tb/sv/tb_lookahead_peak_limiter_core.sv
